>>> hdl/lpfe_pkg.sv
// Shared types, codes and helper function of the LED pixel frame encoder.
`timescale 1ns / 1ps
`default_nettype none

package lpfe_pkg;

   // Strip kinds as held in the strip kind register.
   typedef enum logic [2:0] {
      KIND_RTZ     = 3'd0,
      KIND_BRIGHT  = 3'd1,
      KIND_PLAIN   = 3'd2,
      KIND_FLAG    = 3'd3,
      KIND_RTZ4    = 3'd4
   } strip_kind_type;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_RTZ_PROTOCOL  = 3'd0,
      CSR_STRIP_KIND    = 3'd1,
      CSR_COLOR_MAP     = 3'd2,
      CSR_HIGH_CODE     = 3'd3,
      CSR_LOW_CODE      = 3'd4,
      CSR_BRIGHTNESS    = 3'd5,
      CSR_LED_COUNT     = 3'd6
   } csr_index_type;

   // Colour orders of the rtz encoding.
   localparam logic [2:0] ORDER_RGB = 3'd0;
   localparam logic [2:0] ORDER_RBG = 3'd1;
   localparam logic [2:0] ORDER_GRB = 3'd2;
   localparam logic [2:0] ORDER_GBR = 3'd3;
   localparam logic [2:0] ORDER_BRG = 3'd4;
   localparam logic [2:0] ORDER_BGR = 3'd5;

   // Colour slots: which colour a slot carries.
   localparam logic [1:0] SLOT_RED   = 2'd0;
   localparam logic [1:0] SLOT_GREEN = 2'd1;
   localparam logic [1:0] SLOT_BLUE  = 2'd2;

   localparam logic [7:0] FLAG_BASE = 8'hC0;

   localparam int unsigned ADDR_W  = 15;
   localparam int unsigned INDEX_W = 10;
   localparam int unsigned COUNT_W = 11;

   // Byte counts of the encodings.
   localparam logic [5:0] COUNT_RTZ4  = 6'd32;
   localparam logic [5:0] COUNT_RTZ3  = 6'd24;
   localparam logic [5:0] COUNT_QUAD  = 6'd4;
   localparam logic [5:0] COUNT_TRIPLE = 6'd3;

   typedef struct packed {
      logic                 command;
      logic [INDEX_W-1:0]   led_index;
      logic [7:0]           red;
      logic [7:0]           green;
      logic [7:0]           blue;
      logic [7:0]           white;
   } pixel_type;

   typedef struct packed {
      logic        rtz_protocol;
      logic [2:0]  strip_kind;
      logic [2:0]  color_map;
      logic [7:0]  global_brightness;
   } frame_cfg_type;

   // One pixel job: up to four bytes, lowest byte first, either sent as
   // whole bytes or expanded bit by bit into code bytes.
   typedef struct packed {
      logic                rtz;
      logic [ADDR_W-1:0]   base;
      logic [31:0]         data;
      logic [5:0]          count;
   } job_type;

   typedef struct packed {
      logic [7:0] high_code;
      logic [7:0] low_code;
   } codes_type;

   // Colour carried by a slot for each colour order; unused orders act as RGB.
   function automatic logic [1:0] map_slot(input logic [2:0] map, input logic [1:0] slot);
      logic [5:0] order;
      begin
         case (map)
            ORDER_RBG: order = {SLOT_GREEN, SLOT_BLUE, SLOT_RED};
            ORDER_GRB: order = {SLOT_BLUE, SLOT_RED, SLOT_GREEN};
            ORDER_GBR: order = {SLOT_RED, SLOT_BLUE, SLOT_GREEN};
            ORDER_BRG: order = {SLOT_GREEN, SLOT_RED, SLOT_BLUE};
            ORDER_BGR: order = {SLOT_RED, SLOT_GREEN, SLOT_BLUE};
            default:   order = {SLOT_BLUE, SLOT_GREEN, SLOT_RED};
         endcase
         case (slot)
            2'd0:    map_slot = order[1:0];
            2'd1:    map_slot = order[3:2];
            default: map_slot = order[5:4];
         endcase
      end
   endfunction

endpackage

`default_nettype wire

>>> hdl/lpfe_decode.sv
// Pixel decoder: turns one registered pixel write into a byte job.
`timescale 1ns / 1ps
`default_nettype none

module lpfe_decode
   import lpfe_pkg::*;
(
   input  var pixel_type      pixel,
   input  var frame_cfg_type  cfg,
   input  wire                index_ok,
   output job_type            job
);

   function automatic logic [7:0] pick(input pixel_type p, input logic [1:0] slot);
      begin
         case (slot)
            SLOT_RED:   pick = p.red;
            SLOT_GREEN: pick = p.green;
            default:    pick = p.blue;
         endcase
      end
   endfunction

   logic [7:0] flag_w;

   assign flag_w = FLAG_BASE | {2'b00, ~pixel.blue[7:6], ~pixel.green[7:6], ~pixel.red[7:6]};

   always_comb begin
      job = '0;
      if (index_ok) begin
         if (pixel.command) begin
            if (cfg.strip_kind == KIND_RTZ4) begin
               job.rtz   = 1'b1;
               job.base  = ADDR_W'({pixel.led_index, 5'b00000});
               job.data  = {pixel.white, pixel.blue, pixel.red, pixel.green};
               job.count = COUNT_RTZ4;
            end
         end else if (cfg.rtz_protocol) begin
            job.rtz   = 1'b1;
            job.base  = ADDR_W'({pixel.led_index, 4'b0000}) + ADDR_W'({pixel.led_index, 3'b000});
            job.data  = {8'h00,
                         pick(pixel, map_slot(cfg.color_map, 2'd2)),
                         pick(pixel, map_slot(cfg.color_map, 2'd1)),
                         pick(pixel, map_slot(cfg.color_map, 2'd0))};
            job.count = COUNT_RTZ3;
         end else begin
            case (cfg.strip_kind)
               KIND_BRIGHT: begin
                  job.base  = ADDR_W'({pixel.led_index, 2'b00}) + ADDR_W'(4);
                  job.data  = {pixel.blue, pixel.green, pixel.red, cfg.global_brightness};
                  job.count = COUNT_QUAD;
               end
               KIND_PLAIN: begin
                  job.base  = ADDR_W'({pixel.led_index, 1'b0}) + ADDR_W'(pixel.led_index);
                  job.data  = {8'h00, pixel.blue, pixel.green, pixel.red};
                  job.count = COUNT_TRIPLE;
               end
               KIND_FLAG: begin
                  job.base  = ADDR_W'({pixel.led_index, 2'b00}) + ADDR_W'(4);
                  job.data  = {pixel.red, pixel.green, pixel.blue, flag_w};
                  job.count = COUNT_QUAD;
               end
               default: begin
                  job.count = 6'd0;
               end
            endcase
         end
      end
   end

endmodule

`default_nettype wire

>>> hdl/lpfe_emit.sv
// Byte emitter: holds one job and sends its byte writes one per cycle while rsp_tready is high.
`timescale 1ns / 1ps
`default_nettype none

module lpfe_emit
   import lpfe_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          job_valid,
   input  var job_type  job,
   output logic         job_ready,
   input  var codes_type codes,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [23:0]  rsp_tdata,   // byte_address[14:0], byte_value[22:15], zero[23]
   output logic         rsp_tlast    // last_write
);

   logic        job_valid_ff, job_valid_in;
   job_type     job_ff;
   logic [4:0]  idx_ff, idx_in;

   logic [1:0]        byte_sel_w;
   logic [7:0]        byte_w;
   logic              bit_w;
   logic [7:0]        value_w;
   logic [ADDR_W-1:0] addr_w;
   logic              last_w;
   logic              out_fire_w;
   logic              done_w;
   logic              load_w;

   assign byte_sel_w = job_ff.rtz ? idx_ff[4:3] : idx_ff[1:0];
   assign byte_w     = job_ff.data[8*byte_sel_w +: 8];
   // Code bytes go out most significant bit first.
   assign bit_w      = byte_w[~idx_ff[2:0]];
   assign value_w    = job_ff.rtz ? (bit_w ? codes.high_code : codes.low_code) : byte_w;
   assign addr_w     = job_ff.base + ADDR_W'(idx_ff);
   assign last_w     = ({1'b0, idx_ff} + 6'd1) == job_ff.count;

   assign out_fire_w = job_valid_ff && rsp_tready;
   assign done_w     = out_fire_w && last_w;
   assign job_ready  = !job_valid_ff || done_w;
   // A job with no bytes is consumed without occupying the emitter.
   assign load_w     = job_valid && (job.count != 6'd0);

   assign rsp_tvalid = job_valid_ff;
   assign rsp_tdata  = {1'b0, value_w, addr_w};
   assign rsp_tlast  = last_w;

   always_comb begin
      job_valid_in = job_valid_ff;
      idx_in       = idx_ff;
      if (job_ready) begin
         job_valid_in = load_w;
         idx_in       = 5'd0;
      end else if (out_fire_w) begin
         idx_in = idx_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         idx_ff       <= 5'd0;
      end else begin
         job_valid_ff <= job_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_ready) begin
         job_ff <= job;
      end
   end

   a_idx_in_job: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff |-> ({1'b0, idx_ff} < job_ff.count))
      else $error("byte counter ran past the end of the job");

   a_byte_job_short: assert property (@(posedge clock) disable iff (reset)
      (job_valid_ff && !job_ff.rtz) |-> (job_ff.count <= COUNT_QUAD))
      else $error("whole-byte job longer than four bytes");

   a_drain_idle: assert property (@(posedge clock) disable iff (reset)
      (done_w && !load_w) |=> !job_valid_ff)
      else $error("emitter still busy after its last byte without a new job");

   a_load_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      (job_ready && load_w) |=> (job_valid_ff && idx_ff == 5'd0))
      else $error("new job did not start at its first byte");

endmodule

`default_nettype wire

>>> hdl/led_pixel_frame_encoder_unit.sv
// Top level of the LED pixel frame encoder: configuration, input register, decode, emitter.
// The first byte write of a pixel comes from the emitter's job register, loaded from the input register via decode.
// Output: one byte write per cycle while rsp_tready is high; a pixel holds the emitter until all its
// bytes are sent (32 four-channel, 24 rtz, 4 or 3 byte formats), and the next pixel waits in the input
// register and follows without a gap. Pixels that encode to nothing do not occupy the emitter.
// Reset (synchronous) empties both stages and returns the configuration registers to their reset values.
`timescale 1ns / 1ps
`default_nettype none

module led_pixel_frame_encoder_unit
   import lpfe_pkg::*;
#(
   parameter int MAX_LEDS = 1024
)(
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [47:0]  req_tdata,   // led_index[9:0], red[17:10], green[25:18], blue[33:26],
                                     // white[41:34], zero[47:42]
   input  wire          req_tuser,   // command
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [23:0]  rsp_tdata,   // byte_address[14:0], byte_value[22:15], zero[23]
   output logic         rsp_tlast,   // last_write
   input  wire          csr_we,
   input  wire  [2:0]   csr_index,
   input  wire  [10:0]  csr_wdata
);

   localparam logic [12:0] MaxLedsW = 13'(MAX_LEDS);

   logic               rtz_protocol_ff;
   logic [2:0]         strip_kind_ff;
   logic [2:0]         color_map_ff;
   logic [7:0]         high_code_ff;
   logic [7:0]         low_code_ff;
   logic [7:0]         brightness_ff;
   logic [COUNT_W-1:0] led_count_ff;

   logic          in_valid_ff, in_valid_in;
   pixel_type     pixel_ff, pixel_in;

   frame_cfg_type cfg_w;
   codes_type     codes_w;
   logic          index_ok_w;
   job_type       job_w;
   logic          job_ready_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         rtz_protocol_ff <= 1'b1;
         strip_kind_ff   <= KIND_RTZ;
         color_map_ff    <= 3'd0;
         high_code_ff    <= 8'd0;
         low_code_ff     <= 8'd0;
         brightness_ff   <= 8'd255;
         led_count_ff    <= COUNT_W'(1024);
      end else if (csr_we) begin
         case (csr_index)
            CSR_RTZ_PROTOCOL: rtz_protocol_ff <= csr_wdata[0];
            CSR_STRIP_KIND:   strip_kind_ff   <= csr_wdata[2:0];
            CSR_COLOR_MAP:    color_map_ff    <= csr_wdata[2:0];
            CSR_HIGH_CODE:    high_code_ff    <= csr_wdata[7:0];
            CSR_LOW_CODE:     low_code_ff     <= csr_wdata[7:0];
            CSR_BRIGHTNESS:   brightness_ff   <= csr_wdata[7:0];
            CSR_LED_COUNT:    led_count_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // The input register frees up whenever the emitter takes its job.
   assign req_tready = !in_valid_ff || job_ready_w;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   assign pixel_in.command   = req_tuser;
   assign pixel_in.led_index = req_tdata[9:0];
   assign pixel_in.red       = req_tdata[17:10];
   assign pixel_in.green     = req_tdata[25:18];
   assign pixel_in.blue      = req_tdata[33:26];
   assign pixel_in.white     = req_tdata[41:34];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         pixel_ff <= pixel_in;
      end
   end

   assign index_ok_w = ({1'b0, pixel_ff.led_index} < led_count_ff)
                    && ({3'b000, pixel_ff.led_index} < MaxLedsW);

   assign cfg_w.rtz_protocol      = rtz_protocol_ff;
   assign cfg_w.strip_kind        = strip_kind_ff;
   assign cfg_w.color_map         = color_map_ff;
   assign cfg_w.global_brightness = brightness_ff;

   assign codes_w.high_code = high_code_ff;
   assign codes_w.low_code  = low_code_ff;

   lpfe_decode u_decode (
      .pixel    (pixel_ff),
      .cfg      (cfg_w),
      .index_ok (index_ok_w),
      .job      (job_w)
   );

   lpfe_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (in_valid_ff),
      .job        (job_w),
      .job_ready  (job_ready_w),
      .codes      (codes_w),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
